>>> design/mlp_pkg.sv
// Shared types, register codes and fixed-point helpers of the 2-2-1 perceptron.
package mlp_pkg;

  // APB address width: four 64-bit registers on an 8-byte stride
  localparam int unsigned MLP_ADDR_W = 5;
  localparam int unsigned MLP_DATA_W = 64;

  // Register codes, taken from paddr[4:3]
  typedef enum logic [1:0] {
    REG_HIDDEN_W = 2'd0,
    REG_HIDDEN_B = 2'd1,
    REG_OUTPUT_W = 2'd2,
    REG_OUTPUT_B = 2'd3
  } mlp_reg_e;

  // Network coefficients as held by the register file
  typedef struct packed {
    logic [63:0]        hidden_weights;
    logic [31:0]        hidden_biases;
    logic [31:0]        output_weights;
    logic signed [15:0] output_bias;
  } mlp_cfg_t;

  // Clamp a floored sum to the signed Q4.12 range
  function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
    logic signed [15:0] r;
    if (v > 24'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -24'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Piecewise-linear sigmoid: Q4.12 in, Q0.16 out, 1.0 clamps to all ones
  function automatic logic [15:0] sigmoid(input logic signed [15:0] z);
    logic [15:0] zu;
    logic [15:0] mag;
    logic [16:0] a;
    logic [16:0] y;
    logic [15:0] r;
    zu  = z;
    mag = z[15] ? (~zu + 16'd1) : zu;
    a   = {1'b0, mag};
    if (a < 17'd4096) begin
      y = (a << 2) + 17'd32768;
    end else if (a < 17'd9728) begin
      y = (a << 1) + 17'd40960;
    end else if (a < 17'd20480) begin
      y = (a >> 1) + 17'd55296;
    end else begin
      y = 17'd65536;
    end
    if (z[15]) begin
      y = 17'd65536 - y;
    end
    r = y[16] ? 16'hFFFF : y[15:0];
    return r;
  endfunction

endpackage

>>> design/mlp_cfg_regs.sv
// APB register file holding the weights and biases of the network.
module mlp_cfg_regs
  import mlp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [MLP_ADDR_W-1:0] paddr,
  input  logic [MLP_DATA_W-1:0] pwdata,
  output logic [MLP_DATA_W-1:0] prdata,
  output logic                  pready,
  output mlp_cfg_t              cfg_o
);

  mlp_cfg_t cfg_q, cfg_d;
  mlp_reg_e reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = mlp_reg_e'(paddr[4:3]);
  assign wr_en   = psel & penable & pwrite & pready;

  // Update the addressed register on a completed write transaction
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_HIDDEN_W: cfg_d.hidden_weights = pwdata;
        REG_HIDDEN_B: cfg_d.hidden_biases  = pwdata[31:0];
        REG_OUTPUT_W: cfg_d.output_weights = pwdata[31:0];
        REG_OUTPUT_B: cfg_d.output_bias    = pwdata[15:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Return the addressed register, zero extended
  always_comb begin
    case (reg_sel)
      REG_HIDDEN_W: prdata = cfg_q.hidden_weights;
      REG_HIDDEN_B: prdata = {32'd0, cfg_q.hidden_biases};
      REG_OUTPUT_W: prdata = {32'd0, cfg_q.output_weights};
      REG_OUTPUT_B: prdata = {48'd0, cfg_q.output_bias};
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

`ifndef NO_ASSERTIONS
  a_bias_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && reg_sel == REG_OUTPUT_B) |=> (cfg_q.output_bias == $past(pwdata[15:0])))
    else $error("output bias write not taken");
`endif

endmodule

>>> design/mlp_hidden_layer.sv
// Hidden layer pipeline: two neurons, products, saturated sums and sigmoid.
module mlp_hidden_layer
  import mlp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mlp_cfg_t           cfg_i,
  input  logic               valid_i,
  input  logic signed [15:0] x_first_i,
  input  logic signed [15:0] x_second_i,
  input  logic [15:0]        expected_i,
  output logic               valid_o,
  output logic [15:0]        h_first_o,
  output logic [15:0]        h_second_o,
  output logic [15:0]        expected_o
);

  logic               v1_q, v2_q, v3_q;
  logic [15:0]        exp1_q, exp2_q, exp3_q;
  logic signed [31:0] pa_d [2];
  logic signed [31:0] pb_d [2];
  logic signed [31:0] pa_q [2];
  logic signed [31:0] pb_q [2];
  logic signed [15:0] z_d  [2];
  logic signed [15:0] z_q  [2];
  logic [15:0]        h_d  [2];
  logic [15:0]        h_q  [2];

  // Advance valid bits every cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Carry the target value alongside the data
  always_ff @(posedge clk_i) begin
    exp1_q <= expected_i;
    exp2_q <= exp1_q;
    exp3_q <= exp2_q;
  end

  for (genvar j = 0; j < 2; j++) begin : g_neuron
    logic signed [15:0] w_a, w_b, bias;
    logic signed [33:0] sum;

    assign w_a  = cfg_i.hidden_weights[16*j +: 16];
    assign w_b  = cfg_i.hidden_weights[32 + 16*j +: 16];
    assign bias = cfg_i.hidden_biases[16*j +: 16];

    // Stage 1: multiply each input by its weight
    assign pa_d[j] = x_first_i * w_a;
    assign pb_d[j] = x_second_i * w_b;

    // Stage 2: add bias, floor to Q4.12 and clamp
    assign sum    = {{2{pa_q[j][31]}}, pa_q[j]} + {{2{pb_q[j][31]}}, pb_q[j]}
                  + {{6{bias[15]}}, bias, 12'd0};
    assign z_d[j] = sat16({{2{sum[33]}}, sum[33:12]});

    // Stage 3: activation
    assign h_d[j] = sigmoid(z_q[j]);

    always_ff @(posedge clk_i) begin
      pa_q[j] <= pa_d[j];
      pb_q[j] <= pb_d[j];
      z_q[j]  <= z_d[j];
      h_q[j]  <= h_d[j];
    end
  end

  assign valid_o    = v3_q;
  assign h_first_o  = h_q[0];
  assign h_second_o = h_q[1];
  assign expected_o = exp3_q;

endmodule

>>> design/mlp_output_neuron.sv
// Output neuron pipeline and squared error against the target.
module mlp_output_neuron
  import mlp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mlp_cfg_t    cfg_i,
  input  logic        valid_i,
  input  logic [15:0] h_first_i,
  input  logic [15:0] h_second_i,
  input  logic [15:0] expected_i,
  output logic        valid_o,
  output logic [15:0] y_out_o,
  output logic [15:0] sq_error_o
);

  logic               v4_q, v5_q, v6_q, v7_q;
  logic [15:0]        exp4_q, exp5_q;
  logic signed [15:0] w_a, w_b;
  logic signed [32:0] pa_d, pb_d, pa_q, pb_q;
  logic signed [35:0] sum;
  logic signed [15:0] z_d, z_q;
  logic [15:0]        y_d, y6_q, y7_q;
  logic signed [16:0] diff_d, diff_q;
  logic signed [33:0] sq;
  logic [15:0]        sq_q;

  assign w_a = cfg_i.output_weights[15:0];
  assign w_b = cfg_i.output_weights[31:16];

  // Stage 4: weight the hidden activations
  assign pa_d = $signed({1'b0, h_first_i}) * w_a;
  assign pb_d = $signed({1'b0, h_second_i}) * w_b;

  // Stage 5: add bias, floor Q4.28 to Q4.12 and clamp
  assign sum = {{3{pa_q[32]}}, pa_q} + {{3{pb_q[32]}}, pb_q}
             + {{4{cfg_i.output_bias[15]}}, cfg_i.output_bias, 16'd0};
  assign z_d = sat16({{4{sum[35]}}, sum[35:16]});

  // Stage 6: activation and error against the target
  assign y_d    = sigmoid(z_q);
  assign diff_d = $signed({1'b0, y_d}) - $signed({1'b0, exp5_q});

  // Stage 7: square and scale back to Q0.16
  assign sq = diff_q * diff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      v4_q <= valid_i;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q   <= pa_d;
    pb_q   <= pb_d;
    exp4_q <= expected_i;
    z_q    <= z_d;
    exp5_q <= exp4_q;
    y6_q   <= y_d;
    diff_q <= diff_d;
    y7_q   <= y6_q;
    sq_q   <= sq[31:16];
  end

  assign valid_o    = v7_q;
  assign y_out_o    = y7_q;
  assign sq_error_o = sq_q;

endmodule

>>> design/mlp_2_2_1_sigmoid_forward.sv
// Top level of the 2-2-1 perceptron forward pass with squared error.
// A transaction is taken on every clock edge with start high; busy is always
// low, so one sample enters per cycle without gaps. Each result appears on
// y_out_o and sq_error_o with done_o high for one cycle, once it has passed
// three stages in the hidden layer (multiply, sum and clamp, sigmoid) and
// four in the output neuron (multiply, sum and clamp, sigmoid and difference,
// square). Results cannot be held off and must be taken in the cycle they
// appear. Coefficients are written over APB at byte addresses 0, 8, 16 and
// 24, by the user only while no sample is in flight (the block does not check).
module mlp_2_2_1_sigmoid_forward
  import mlp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [MLP_ADDR_W-1:0] paddr,
  input  logic [MLP_DATA_W-1:0] pwdata,
  output logic [MLP_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [15:0]    x_first_i,
  input  logic signed [15:0]    x_second_i,
  input  logic [15:0]           expected_i,
  output logic                  done_o,
  output logic [15:0]           y_out_o,
  output logic [15:0]           sq_error_o
);

  mlp_cfg_t    cfg;
  logic        accept;
  logic        hid_valid;
  logic [15:0] h_first, h_second, hid_expected;

  // Pipeline never stalls
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  mlp_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mlp_hidden_layer u_hidden (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .valid_i    (accept),
    .x_first_i  (x_first_i),
    .x_second_i (x_second_i),
    .expected_i (expected_i),
    .valid_o    (hid_valid),
    .h_first_o  (h_first),
    .h_second_o (h_second),
    .expected_o (hid_expected)
  );

  mlp_output_neuron u_output (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .valid_i    (hid_valid),
    .h_first_i  (h_first),
    .h_second_i (h_second),
    .expected_i (hid_expected),
    .valid_o    (done_o),
    .y_out_o    (y_out_o),
    .sq_error_o (sq_error_o)
  );

`ifndef NO_ASSERTIONS
  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##7 done_o)
    else $error("accepted transaction produced no result");

  a_latency_bwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 7))
    else $error("result without a matching transaction");
`endif

endmodule
